>>> sv/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, ignored while aresetn is low.
`define IGNA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define IGNA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> sv/igna_pkg.sv
package igna_pkg;

    localparam int FW_BITS       = 6;
    localparam int FH_BITS       = 10;
    localparam int THR_BITS      = 4;
    localparam int ROW_BITS      = 10;
    localparam int OUT_COL_BITS  = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam int NUM_BANKS     = 3;
    localparam int NUM_NBR       = 4;

    typedef logic [1:0]              bank_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_FRAME_WIDTH      = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FRAME_HEIGHT     = cfg_idx_t'(1);
    localparam cfg_idx_t REG_GLITCH_THRESHOLD = cfg_idx_t'(2);

    localparam logic [FW_BITS-1:0]  FW_RESET  = 6'd30;
    localparam logic [FH_BITS-1:0]  FH_RESET  = 10'd20;
    localparam logic [THR_BITS-1:0] THR_RESET = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EVAL,
        ST_MEAN,
        ST_OUT
    } state_t;

    // Which pixel a result belongs to, relative to the request that caused it.
    typedef enum logic [1:0] {
        SLOT_UPPER,
        SLOT_LEFT,
        SLOT_SELF
    } slot_t;

    // Banks rotate 0 -> 1 -> 2 -> 0 as rows complete.
    function automatic bank_t bank_prev(bank_t b);
        bank_t p;
        case (b)
            2'd0:    p = 2'd2;
            2'd1:    p = 2'd0;
            default: p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic bank_t bank_succ(bank_t b);
        bank_t s;
        case (b)
            2'd0:    s = 2'd1;
            2'd1:    s = 2'd2;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

>>> sv/image_glitch_neighbor_average.sv
// Requests are taken one at a time (s_tready is high only in ST_IDLE). Each passes
// READ and LOAD, then EVAL, MEAN and OUT per result and a last EVAL back to idle, for
// n = 0..3 results (row 0: none, inner rows: one, last row: up to three); the single
// mean unit takes them in turn; a stall holds ST_OUT until the output register frees.
// Reset (aresetn low, synchronous): position, bank rotation, state and m_tvalid
// cleared, registers back to defaults; line stores are not cleared.
module image_glitch_neighbor_average #(
    parameter int MAX_WIDTH  = 32,
    parameter int LEVEL_BITS = 4,
    localparam int S_TDATA_W = ((LEVEL_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((LEVEL_BITS + igna_pkg::ROW_BITS
                                 + igna_pkg::OUT_COL_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input pixels
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_W-1:0]               s_tdata,   // pixel_level
    input  logic [0:0]                         s_tuser,   // frame_start
    // filtered pixels
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,   // filtered_level, out_row, out_col
    output logic [0:0]                         m_tuser,   // was_glitch
    output logic                               m_tlast,   // frame_last
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  igna_pkg::cfg_idx_t                 cfg_index,
    input  logic [igna_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    // Wide enough for both the clamped width and the raw register.
    localparam int CMP_BITS = (COL_BITS + 1 > igna_pkg::FW_BITS) ? COL_BITS + 1
                                                                 : igna_pkg::FW_BITS;
    localparam int RB = igna_pkg::ROW_BITS;
    localparam int NN = igna_pkg::NUM_NBR;

    // ---------------------------------------------------------------- registers
    logic [igna_pkg::FW_BITS-1:0]  width_reg;
    logic [igna_pkg::FH_BITS-1:0]  height_reg;
    logic [igna_pkg::THR_BITS-1:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= igna_pkg::FW_RESET;
            height_reg <= igna_pkg::FH_RESET;
            thr_reg    <= igna_pkg::THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                igna_pkg::REG_FRAME_WIDTH:      width_reg  <= cfg_data[igna_pkg::FW_BITS-1:0];
                igna_pkg::REG_FRAME_HEIGHT:     height_reg <= cfg_data[igna_pkg::FH_BITS-1:0];
                igna_pkg::REG_GLITCH_THRESHOLD: thr_reg    <= cfg_data[igna_pkg::THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- frame geometry
    logic [CMP_BITS-1:0] fw_ext;
    logic [CMP_BITS-1:0] w_eff;
    logic [RB-1:0]       h_eff;

    always_comb begin
        fw_ext = CMP_BITS'(width_reg);
        if (fw_ext < CMP_BITS'(2)) begin
            w_eff = CMP_BITS'(2);
        end else if (fw_ext > CMP_BITS'(MAX_WIDTH)) begin
            w_eff = CMP_BITS'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        h_eff = (height_reg < RB'(2)) ? RB'(2) : height_reg;
    end

    // ------------------------------------------------------------ state
    igna_pkg::state_t state_reg, state_next;
    igna_pkg::bank_t  cur_bank_reg, cur_bank_next;
    logic [RB-1:0]       row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;

    // request held for the whole of its work
    logic [RB-1:0]       item_row_reg;
    logic [COL_BITS-1:0] item_col_reg;
    logic                item_left_reg;
    logic                item_left2_reg;
    logic                item_right_reg;
    logic                item_up2_reg;
    logic                item_lastcol_reg;
    logic [2:0]          mask_reg, mask_next;
    igna_pkg::slot_t     slot_reg, slot_pick;

    // last three pixels of the current row: hist0 is the request's own
    logic [LEVEL_BITS-1:0] hist0_reg, hist1_reg, hist2_reg;
    // above row around the column, and the row two above
    logic [LEVEL_BITS-1:0] al_reg, ac_reg, ar_reg, tw_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [LEVEL_BITS-1:0] out_level_reg;
    logic [RB-1:0]         out_row_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic                  out_glitch_reg;
    logic                  out_last_reg;

    // ----------------------------------------------------- request position
    logic                  accept;
    logic [LEVEL_BITS-1:0] pixel;
    logic                  restart;
    logic [RB-1:0]         r_c;
    logic [COL_BITS-1:0]   c_c;
    logic [CMP_BITS-1:0]   c_ext;
    logic                  last_col_c;
    logic                  last_row_c;
    logic                  has_left_c;
    logic                  has_right_c;

    assign s_tready = (state_reg == igna_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pixel    = s_tdata[LEVEL_BITS-1:0];

    always_comb begin
        // frame_start or a position left outside a shrunk frame restarts at 0,0
        restart     = s_tuser[0] || (CMP_BITS'(col_reg) >= w_eff) || (row_reg >= h_eff);
        r_c         = restart ? '0 : row_reg;
        c_c         = restart ? '0 : col_reg;
        c_ext       = CMP_BITS'(c_c);
        last_col_c  = (c_ext == w_eff - CMP_BITS'(1));
        last_row_c  = (r_c == h_eff - RB'(1));
        has_left_c  = (c_c != '0);
        has_right_c = (c_ext + CMP_BITS'(1) < w_eff);
    end

    // ---------------------------------------------------------- line stores
    igna_pkg::bank_t       above_bank, two_bank;
    igna_pkg::bank_t       rd_bank_a, rd_bank_b;
    logic [COL_BITS-1:0]   rd_col_a, rd_col_b;
    logic [LEVEL_BITS-1:0] rd_data_a, rd_data_b;

    always_comb begin
        above_bank = igna_pkg::bank_prev(cur_bank_reg);
        two_bank   = igna_pkg::bank_prev(above_bank);
        if (state_reg == igna_pkg::ST_IDLE) begin
            // left and right of the column in the row above
            rd_bank_a = above_bank;
            rd_col_a  = has_left_c ? c_c - COL_BITS'(1) : c_c;
            rd_bank_b = above_bank;
            rd_col_b  = has_right_c ? c_c + COL_BITS'(1) : c_c;
        end else begin
            // straight above, and two rows up
            rd_bank_a = above_bank;
            rd_col_a  = item_col_reg;
            rd_bank_b = two_bank;
            rd_col_b  = item_col_reg;
        end
    end

    igna_line_mem #(
        .LEVEL_BITS (LEVEL_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_line_mem (
        .aclk      (aclk),
        .wr_en     (accept),
        .wr_bank   (cur_bank_reg),
        .wr_col    (c_c),
        .wr_data   (pixel),
        .rd_bank_a (rd_bank_a),
        .rd_col_a  (rd_col_a),
        .rd_bank_b (rd_bank_b),
        .rd_col_b  (rd_col_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // --------------------------------------------------------- mean unit
    logic                            ev_start;
    logic [LEVEL_BITS-1:0]           ev_center;
    logic [NN-1:0][LEVEL_BITS-1:0]   ev_nbr;       // left, right, up, down
    logic [NN-1:0]                   ev_ok;
    logic                            ev_glitch;
    logic [LEVEL_BITS-1:0]           ev_level;

    always_comb begin
        // lowest pending result first: pixel above, then left, then own
        if (mask_reg[0]) begin
            slot_pick = igna_pkg::SLOT_UPPER;
        end else if (mask_reg[1]) begin
            slot_pick = igna_pkg::SLOT_LEFT;
        end else begin
            slot_pick = igna_pkg::SLOT_SELF;
        end

        case (slot_pick)
            igna_pkg::SLOT_UPPER: begin
                ev_center = ac_reg;
                ev_nbr    = {hist0_reg, tw_reg, ar_reg, al_reg};
                ev_ok     = {1'b1, item_up2_reg, item_right_reg, item_left_reg};
            end
            igna_pkg::SLOT_LEFT: begin
                ev_center = hist1_reg;
                ev_nbr    = {hist0_reg, al_reg, hist0_reg, hist2_reg};
                ev_ok     = {1'b0, 1'b1, 1'b1, item_left2_reg};
            end
            igna_pkg::SLOT_SELF: begin
                ev_center = hist0_reg;
                ev_nbr    = {hist0_reg, ac_reg, hist0_reg, hist1_reg};
                ev_ok     = {1'b0, 1'b1, 1'b0, 1'b1};
            end
            default: begin
                ev_center = hist0_reg;
                ev_nbr    = {hist0_reg, hist0_reg, hist0_reg, hist0_reg};
                ev_ok     = '0;
            end
        endcase
    end

    igna_eval #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ev_start),
        .center  (ev_center),
        .nbr     (ev_nbr),
        .nbr_ok  (ev_ok),
        .thr     (thr_reg),
        .glitch  (ev_glitch),
        .level   (ev_level)
    );

    // ------------------------------------------------------ sequencer
    logic out_load;

    always_comb begin
        state_next     = state_reg;
        cur_bank_next  = cur_bank_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        mask_next      = mask_reg;
        ev_start       = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            igna_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = igna_pkg::ST_READ;
                    mask_next  = {last_row_c && last_col_c,
                                  last_row_c && has_left_c,
                                  r_c != '0};
                    if (last_col_c) begin
                        col_next = '0;
                        row_next = last_row_c ? '0 : r_c + RB'(1);
                    end else begin
                        row_next = r_c;
                        col_next = c_c + COL_BITS'(1);
                    end
                end
            end
            igna_pkg::ST_READ: begin
                state_next = igna_pkg::ST_LOAD;
            end
            igna_pkg::ST_LOAD: begin
                state_next = igna_pkg::ST_EVAL;
            end
            igna_pkg::ST_EVAL: begin
                if (mask_reg == '0) begin
                    // request done; a finished row becomes the row above
                    state_next = igna_pkg::ST_IDLE;
                    if (item_lastcol_reg) begin
                        cur_bank_next = igna_pkg::bank_succ(cur_bank_reg);
                    end
                end else begin
                    ev_start   = 1'b1;
                    state_next = igna_pkg::ST_MEAN;
                    case (slot_pick)
                        igna_pkg::SLOT_UPPER: mask_next = mask_reg & 3'b110;
                        igna_pkg::SLOT_LEFT:  mask_next = mask_reg & 3'b101;
                        default:              mask_next = mask_reg & 3'b011;
                    endcase
                end
            end
            igna_pkg::ST_MEAN: begin
                state_next = igna_pkg::ST_OUT;
            end
            igna_pkg::ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = igna_pkg::ST_EVAL;
                end
            end
            default: begin
                state_next = igna_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= igna_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_bank_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_bank_reg  <= cur_bank_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_row_reg     <= r_c;
            item_col_reg     <= c_c;
            item_left_reg    <= has_left_c;
            item_left2_reg   <= (c_c > COL_BITS'(1));
            item_right_reg   <= has_right_c;
            item_up2_reg     <= (r_c > RB'(1));
            item_lastcol_reg <= last_col_c;
            hist0_reg        <= pixel;
            hist1_reg        <= hist0_reg;
            hist2_reg        <= hist1_reg;
        end
        if (state_reg == igna_pkg::ST_READ) begin
            al_reg <= rd_data_a;
            ar_reg <= rd_data_b;
        end
        if (state_reg == igna_pkg::ST_LOAD) begin
            ac_reg <= rd_data_a;
            tw_reg <= rd_data_b;
        end
        if (ev_start) begin
            slot_reg <= slot_pick;
        end
        if (out_load) begin
            out_level_reg  <= ev_level;
            out_glitch_reg <= ev_glitch;
            out_row_reg    <= (slot_reg == igna_pkg::SLOT_UPPER) ? item_row_reg - RB'(1)
                                                                 : item_row_reg;
            out_col_reg    <= (slot_reg == igna_pkg::SLOT_LEFT) ? item_col_reg - COL_BITS'(1)
                                                                : item_col_reg;
            out_last_reg   <= (slot_reg == igna_pkg::SLOT_SELF);
        end
    end

    // ------------------------------------------------------------ outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({igna_pkg::OUT_COL_BITS'(out_col_reg), out_row_reg,
                                  out_level_reg});
    assign m_tuser  = out_glitch_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/igna_line_mem.sv
module igna_line_mem #(
    parameter int LEVEL_BITS = 4,
    parameter int MAX_WIDTH  = 32,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  igna_pkg::bank_t       wr_bank,
    input  logic [COL_BITS-1:0]   wr_col,
    input  logic [LEVEL_BITS-1:0] wr_data,
    input  igna_pkg::bank_t       rd_bank_a,
    input  logic [COL_BITS-1:0]   rd_col_a,
    input  igna_pkg::bank_t       rd_bank_b,
    input  logic [COL_BITS-1:0]   rd_col_b,
    output logic [LEVEL_BITS-1:0] rd_data_a,
    output logic [LEVEL_BITS-1:0] rd_data_b
);

    // Three row banks; one write and two registered reads per cycle.
    logic [LEVEL_BITS-1:0] line_store_reg [igna_pkg::NUM_BANKS][MAX_WIDTH];
    logic [LEVEL_BITS-1:0] rd_data_a_reg;
    logic [LEVEL_BITS-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store_reg[wr_bank][wr_col] <= wr_data;
        end
        rd_data_a_reg <= line_store_reg[rd_bank_a][rd_col_a];
        rd_data_b_reg <= line_store_reg[rd_bank_b][rd_col_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

>>> sv/igna_eval.sv
module igna_eval #(
    parameter int LEVEL_BITS = 4
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [LEVEL_BITS-1:0]                      center,
    input  logic [igna_pkg::NUM_NBR-1:0][LEVEL_BITS-1:0] nbr,
    input  logic [igna_pkg::NUM_NBR-1:0]               nbr_ok,
    input  logic [igna_pkg::THR_BITS-1:0]              thr,
    output logic                                       glitch,
    output logic [LEVEL_BITS-1:0]                      level
);

    // Sum of up to five levels, mean by reciprocal multiply on a glitch, else the centre.
    localparam int SUM_BITS  = LEVEL_BITS + 3;
    localparam int DIF_BITS  = (LEVEL_BITS > igna_pkg::THR_BITS) ? LEVEL_BITS
                                                                 : igna_pkg::THR_BITS;
    localparam int SH        = SUM_BITS + 3;
    localparam int MUL_BITS  = SH + 1;
    localparam int PROD_BITS = SUM_BITS + MUL_BITS;

    localparam logic [MUL_BITS-1:0] RCP1 = MUL_BITS'(2 ** SH);
    localparam logic [MUL_BITS-1:0] RCP2 = MUL_BITS'(2 ** (SH - 1));
    localparam logic [MUL_BITS-1:0] RCP3 = MUL_BITS'((2 ** SH + 2) / 3);
    localparam logic [MUL_BITS-1:0] RCP4 = MUL_BITS'(2 ** (SH - 2));
    localparam logic [MUL_BITS-1:0] RCP5 = MUL_BITS'((2 ** SH + 4) / 5);

    logic [DIF_BITS-1:0]   dif_c [igna_pkg::NUM_NBR];
    logic                  hit_c;
    logic [SUM_BITS-1:0]   sum_c;
    logic [2:0]            cnt_c;

    logic                  v1_reg;
    logic                  hit_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [2:0]            cnt_reg;
    logic [LEVEL_BITS-1:0] ctr_reg;

    logic [MUL_BITS-1:0]   rcp_c;
    logic [PROD_BITS-1:0]  prod_c;

    logic                  glitch_reg;
    logic [LEVEL_BITS-1:0] level_reg;

    always_comb begin
        hit_c = 1'b0;
        sum_c = SUM_BITS'(center);
        cnt_c = 3'd1;
        for (int i = 0; i < igna_pkg::NUM_NBR; i++) begin
            dif_c[i] = (nbr[i] > center) ? DIF_BITS'(nbr[i]) - DIF_BITS'(center)
                                         : DIF_BITS'(center) - DIF_BITS'(nbr[i]);
            if (nbr_ok[i]) begin
                hit_c = hit_c | (dif_c[i] > DIF_BITS'(thr));
                sum_c = sum_c + SUM_BITS'(nbr[i]);
                cnt_c = cnt_c + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            hit_reg <= hit_c;
            sum_reg <= sum_c;
            cnt_reg <= cnt_c;
            ctr_reg <= center;
        end
    end

    always_comb begin
        case (cnt_reg)
            3'd2:    rcp_c = RCP2;
            3'd3:    rcp_c = RCP3;
            3'd4:    rcp_c = RCP4;
            3'd5:    rcp_c = RCP5;
            default: rcp_c = RCP1;
        endcase
        prod_c = PROD_BITS'(sum_reg) * PROD_BITS'(rcp_c);
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            glitch_reg <= hit_reg;
            level_reg  <= hit_reg ? prod_c[SH +: LEVEL_BITS] : ctr_reg;
        end
    end

    assign glitch = glitch_reg;
    assign level  = level_reg;

endmodule

>>> sv/igna_checker.sv
`include "assert_macros.svh"

module igna_checker #(
    parameter int TDATA_BITS = 24
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic [0:0]            m_tuser,
    input logic                  m_tlast
);

    // reset empties the output register
    `IGNA_ASSERT_ALWAYS(a_rst_out_empty, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

    // a stalled result holds
    `IGNA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // one request at a time: busy right after taking one
    `IGNA_ASSERT(a_busy_after_req, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // a fresh result only comes out of a request still in progress
    `IGNA_ASSERT(a_new_result_busy, m_tvalid && (!$past(m_tvalid) || $past(m_tready)) |-> !s_tready, "new result while idle")

endmodule

bind image_glitch_neighbor_average igna_checker #(
    .TDATA_BITS (M_TDATA_W)
) u_igna_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> dv/tb_image_glitch_neighbor_average.sv
`timescale 1ns / 100ps

module tb_image_glitch_neighbor_average;

    localparam int LVL_W     = 4;
    localparam int MAX_W     = 32;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;
    localparam int DRAIN_CYC = 40;       // drain margin after the last expected pixel, for requests that emit nothing
    localparam int HOLD_CYC  = 400;      // receiver hold-off in the backpressure test
    localparam int CYC_LIMIT = 300000;

    // One emitted pixel as the filter should produce it.
    typedef struct packed {
        logic [LVL_W-1:0]                  level;
        logic [igna_pkg::ROW_BITS-1:0]     row;
        logic [igna_pkg::OUT_COL_BITS-1:0] col;
        logic                              glitch;
        logic                              last;
    } filt_pixel_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [S_DATA_W-1:0]                s_tdata   = '0;   // pixel_level
    logic [0:0]                         s_tuser   = '0;   // frame_start
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [M_DATA_W-1:0]                m_tdata;          // filtered_level, out_row, out_col
    logic [0:0]                         m_tuser;          // was_glitch
    logic                               m_tlast;          // frame_last
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    igna_pkg::cfg_idx_t                 cfg_index = igna_pkg::REG_FRAME_WIDTH;
    logic [igna_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

    image_glitch_neighbor_average DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Filter shadow: register copies, line stores and frame position
    // ---------------------------------------------------------------
    int               frame_w   = igna_pkg::FW_RESET;
    int               frame_h   = igna_pkg::FH_RESET;
    int               glitch_th = igna_pkg::THR_RESET;
    logic [LVL_W-1:0] line_two_up [MAX_W];
    logic [LVL_W-1:0] line_up     [MAX_W];
    logic [LVL_W-1:0] line_now    [MAX_W];
    int               row_pos   = 0;
    int               col_pos   = 0;

    filt_pixel_t expected_pixels[$];

    int tx_idle_pct  = 0;     // chance in a hundred of a sender gap cycle
    int rx_stall_pct = 0;     // chance in a hundred of the receiver stalling
    logic rx_hold    = 1'b0;  // long receiver hold-off, driven by its own process
    int fail_count   = 0;
    int cycle_count  = 0;

    // Neighbour order: left, right, up, down. Mean only when some existing
    // neighbour differs by more than the threshold.
    function automatic void deglitch_pixel(input logic [LVL_W-1:0] ctr,
                                           input logic [3:0][LVL_W-1:0] nb,
                                           input logic [3:0] has, input int row,
                                           input int col, input logic last);
        int sum;
        int cnt;
        int d;
        logic glitch;
        filt_pixel_t res;
        sum    = ctr;
        cnt    = 1;
        glitch = 1'b0;
        for (int k = 0; k < 4; k++) begin
            d = int'(nb[k]) - int'(ctr);
            if (has[k] && ((d < 0) ? -d : d) > glitch_th)
                glitch = 1'b1;
        end
        if (glitch) begin
            for (int k = 0; k < 4; k++) begin
                if (has[k]) begin
                    sum += nb[k];
                    cnt++;
                end
            end
        end
        res.level  = LVL_W'(sum / cnt);
        res.row    = igna_pkg::ROW_BITS'(row);
        res.col    = igna_pkg::OUT_COL_BITS'(col);
        res.glitch = glitch;
        res.last   = last;
        expected_pixels.push_back(res);
    endfunction

    // Advance the shadow by one accepted pixel and queue what it releases: the
    // pixel above it, and in the last row the left pixel and, in the last column, itself.
    function automatic void predict_filtered(input logic [LVL_W-1:0] lvl,
                                             input logic fs);
        int w;
        int h;
        int r;
        int c;
        logic [3:0][LVL_W-1:0] nb;
        logic [3:0] has;
        w = (frame_w < 2) ? 2 : (frame_w > MAX_W) ? MAX_W : frame_w;
        h = (frame_h < 2) ? 2 : frame_h;
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        // position left outside the frame by a register change: new frame
        if (col_pos >= w || row_pos >= h) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        line_now[c] = lvl;
        if (r >= 1) begin
            nb  = '0;
            has = {1'b1, (r >= 2) ? 1'b1 : 1'b0, (c + 1 < w) ? 1'b1 : 1'b0,
                   (c >= 1) ? 1'b1 : 1'b0};
            if (c >= 1)
                nb[0] = line_up[c-1];
            if (c + 1 < w)
                nb[1] = line_up[c+1];
            if (r >= 2)
                nb[2] = line_two_up[c];
            nb[3] = lvl;
            deglitch_pixel(line_up[c], nb, has, r - 1, c, 1'b0);
        end
        if (r == h - 1) begin
            if (c >= 1) begin
                nb    = '0;
                has   = {1'b0, 1'b1, 1'b1, (c >= 2) ? 1'b1 : 1'b0};
                if (c >= 2)
                    nb[0] = line_now[c-2];
                nb[1] = lvl;
                nb[2] = line_up[c-1];
                deglitch_pixel(line_now[c-1], nb, has, r, c - 1, 1'b0);
            end
            if (c == w - 1) begin
                nb    = '0;
                has   = 4'b0101;
                nb[0] = line_now[c-1];
                nb[2] = line_up[c];
                deglitch_pixel(lvl, nb, has, r, c, 1'b1);
            end
        end
        if (c == w - 1) begin
            line_two_up = line_up;
            line_up     = line_now;
            col_pos     = 0;
            row_pos     = (r == h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Offer one pixel, with random gaps before it; valid stays high after
    // the request so back-to-back pixels carry no bubble.
    task automatic send_pixel(input logic [LVL_W-1:0] lvl, input logic fs);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(lvl);
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_filtered(lvl, fs);
    endtask

    task automatic write_reg(input igna_pkg::cfg_idx_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= igna_pkg::CFG_DATA_BITS'(val);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            igna_pkg::REG_FRAME_WIDTH:      frame_w   = val & 'h3f;
            igna_pkg::REG_FRAME_HEIGHT:     frame_h   = val & 'h3ff;
            igna_pkg::REG_GLITCH_THRESHOLD: glitch_th = val & 'hf;
            default: ;
        endcase
    endtask

    // Only called with the filter idle.
    task automatic configure(input int w, input int h, input int thr);
        write_reg(igna_pkg::REG_FRAME_WIDTH, w);
        write_reg(igna_pkg::REG_FRAME_HEIGHT, h);
        write_reg(igna_pkg::REG_GLITCH_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every expected pixel out, then give any request
    // that emits nothing (row 0) time to finish inside the filter.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // Frame-shaped traffic under the current registers: frame_start always on
    // the first pixel of the call, since the width may have grown, and at random
    // on later frame starts; smooth content with spikes, and now and then a frame cut
    // short by an early frame_start.
    task automatic random_frames(input int n_items);
        int pos;
        int base;
        int jit;
        int v;
        logic fs;
        pos  = 0;
        base = 0;
        for (int i = 0; i < n_items; i++) begin
            if (pos > 0 && $urandom_range(99) < 4)
                pos = 0;
            fs = 1'b0;
            if (pos == 0) begin
                base = $urandom_range(0, 15);
                fs   = (i == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                if (i > 0 && !fs && col_pos != 0)
                    fs = 1'b1;
            end
            if ($urandom_range(99) < 25) begin
                v = $urandom_range(0, 15);
            end else begin
                jit = $urandom_range(0, 2);
                v   = base + jit - 1;
                v   = (v < 0) ? 0 : (v > 15) ? 15 : v;
            end
            send_pixel(LVL_W'(v), fs);
            pos++;
            if (pos == frame_w * frame_h)
                pos = 0;
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver and result check
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        filt_pixel_t got;
        filt_pixel_t exp_pix;
        if (aresetn && m_tvalid && m_tready) begin
            got.level  = m_tdata[LVL_W-1:0];
            got.row    = m_tdata[LVL_W +: igna_pkg::ROW_BITS];
            got.col    = m_tdata[LVL_W+igna_pkg::ROW_BITS +: igna_pkg::OUT_COL_BITS];
            got.glitch = m_tuser[0];
            got.last   = m_tlast;
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pixel: level %0d row %0d col %0d glitch %0d last %0d",
                             got.level, got.row, got.col, got.glitch, got.last);
            end else begin
                exp_pix = expected_pixels.pop_front();
                if (got !== exp_pix) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected level %0d row %0d col %0d glitch %0d",
                                  " last %0d, got level %0d row %0d col %0d glitch %0d",
                                  " last %0d"},
                                 exp_pix.level, exp_pix.row, exp_pix.col, exp_pix.glitch,
                                 exp_pix.last, got.level, got.row, got.col, got.glitch,
                                 got.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYC_LIMIT) begin
            $display("image_glitch_neighbor_average regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // 3x3 frame of extremes, threshold 0: corners, edges, centre, and the
    // three-pixel flush of the last row.
    task automatic test_border_glitch();
        logic [LVL_W-1:0] px [9];
        px = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd15, 4'd15};
        rx_stall_pct <= 0;
        tx_idle_pct  = 0;
        configure(3, 3, 0);
        for (int i = 0; i < 9; i++)
            send_pixel(px[i], (i == 0) ? 1'b1 : 1'b0);
        wait_drain();
    endtask

    // Narrowing the width under a part-done row: next pixel opens a frame.
    task automatic test_width_out_of_range();
        configure(3, 2, 1);
        send_pixel(4'd9, 1'b1);
        send_pixel(4'd2, 1'b0);
        wait_drain();
        configure(2, 2, 1);
        send_pixel(4'd0, 1'b0);
        send_pixel(4'd8, 1'b0);
        send_pixel(4'd15, 1'b0);
        send_pixel(4'd7, 1'b0);
        wait_drain();
    endtask

    // Lowering the height below the current row: same restart.
    task automatic test_height_out_of_range();
        configure(2, 3, 1);
        send_pixel(4'd3, 1'b1);
        send_pixel(4'd4, 1'b0);
        send_pixel(4'd12, 1'b0);
        send_pixel(4'd5, 1'b0);
        wait_drain();
        configure(2, 2, 1);
        send_pixel(4'd6, 1'b0);
        send_pixel(4'd1, 1'b0);
        send_pixel(4'd14, 1'b0);
        send_pixel(4'd6, 1'b0);
        wait_drain();
    endtask

    task automatic test_full_rate();
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
        configure(2, 2, 0);
        random_frames(40);
        wait_drain();
        configure(MAX_W, 2, 15);
        random_frames(45);
        wait_drain();
    endtask

    task automatic test_sender_gaps();
        tx_idle_pct  = 55;
        rx_stall_pct <= 0;
        configure(5, 4, $urandom_range(0, 4));
        random_frames(40);
        wait_drain();
        // tallest frame: only the top rows are reached
        configure(4, 1023, 3);
        random_frames(30);
        wait_drain();
    endtask

    task automatic test_receiver_stalls();
        tx_idle_pct  = 0;
        rx_stall_pct <= 55;
        for (int p = 0; p < 2; p++) begin
            configure($urandom_range(2, 8), $urandom_range(2, 6), $urandom_range(0, 4));
            random_frames(30);
            wait_drain();
        end
    endtask

    task automatic test_both_idle();
        tx_idle_pct  = 19;
        rx_stall_pct <= 19;
        for (int p = 0; p < 2; p++) begin
            configure($urandom_range(2, 12), $urandom_range(2, 5), $urandom_range(0, 15));
            random_frames(30);
            wait_drain();
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the output
    // register fills and s_tready stays low.
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
        configure(6, 3, 2);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYC) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            random_frames(30);
        join
        wait_drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_border_glitch();
        test_width_out_of_range();
        test_height_out_of_range();
        test_full_rate();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();

        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("image_glitch_neighbor_average regression: pass");
        else
            $display("image_glitch_neighbor_average regression: fail");
        $finish;
    end

endmodule
